// ===== src/grcc_pkg.sv =====
// Shared constants, stage payload types and helpers for the grid ray caster.
package grcc_pkg;

  localparam int MAP_SIZE     = 8;
  localparam int FRAC_BITS    = 12;
  localparam int SCREEN_WIDTH = 640;
  localparam int DDA_STEPS    = 2 * MAP_SIZE + 2;
  localparam int DIV_BITS     = 13;
  localparam int LINE_SAT     = 2048;

  // cam numerator is column * 2^(F+1) / 640 = column * 64 / 5; divide by 5 by reciprocal
  localparam int CAM_MUL_SHIFT = FRAC_BITS + 1 - 7;
  localparam logic [16:0] CAM_RECIP = 17'd52429;
  localparam int CAM_RECIP_SHIFT = 18;

  localparam logic [16:0] ONE = 17'(1 << FRAC_BITS);

  typedef enum logic [2:0] {
    REG_PLAYER_X      = 3'd0,
    REG_PLAYER_Y      = 3'd1,
    REG_DIR_X         = 3'd2,
    REG_DIR_Y         = 3'd3,
    REG_PLANE_X       = 3'd4,
    REG_PLANE_Y       = 3'd5,
    REG_MAP_WALLS     = 3'd6,
    REG_SCREEN_HEIGHT = 3'd7
  } reg_index_t;

  typedef struct packed {
    logic              valid;
    logic [9:0]        column;
    logic [16:0]       ax;
    logic [16:0]       ay;
    logic              neg_x;
    logic              neg_y;
    logic [16:0]       tx;
    logic [16:0]       ty;
    logic signed [5:0] mx;
    logic signed [5:0] my;
    logic              side;
    logic [16:0]       tprev;
    logic              stepped;
    logic              done;
  } dda_t;

  typedef struct packed {
    logic                valid;
    logic [9:0]          column;
    logic                side;
    logic [2:0]          hit_x;
    logic [2:0]          hit_y;
    logic [8:0]          half_h;
    logic [26:0]         rem;
    logic [16:0]         den;
    logic [DIV_BITS-1:0] quot;
    logic                sat;
  } div_t;

  function automatic logic is_wall(logic signed [5:0] x, logic signed [5:0] y,
                                   logic [63:0] walls);
    logic [5:0] idx;
    idx = 6'(y * MAP_SIZE + x);
    if (x < 0 || y < 0 || x >= 6'(MAP_SIZE) || y >= 6'(MAP_SIZE)) begin
      return 1'b1;
    end
    return walls[idx];
  endfunction

  function automatic logic [2:0] clamp_cell(logic signed [5:0] c);
    if (c < 0) begin
      return 3'd0;
    end
    if (c > 6'(MAP_SIZE - 1)) begin
      return 3'(MAP_SIZE - 1);
    end
    return c[2:0];
  endfunction

endpackage

// ===== src/grcc_dda_step.sv =====
// One registered DDA step: wall test at the current cell, else advance one cell.
module grcc_dda_step (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic [63:0]        map_walls,
  input  grcc_pkg::dda_t     din,
  output grcc_pkg::dda_t     dout
);
  import grcc_pkg::*;

  logic [33:0] cross_x;
  logic [33:0] cross_y;
  dda_t        nxt;

  assign cross_x = 34'(din.tx) * 34'(din.ay);
  assign cross_y = 34'(din.ty) * 34'(din.ax);

  always_comb begin
    nxt = din;
    if (!din.done) begin
      if (is_wall(din.mx, din.my, map_walls)) begin
        nxt.done = 1'b1;
      end else if (cross_x < cross_y) begin
        nxt.tprev   = din.tx;
        nxt.tx      = din.tx + ONE;
        nxt.mx      = din.neg_x ? din.mx - 6'sd1 : din.mx + 6'sd1;
        nxt.side    = 1'b0;
        nxt.stepped = 1'b1;
      end else begin
        nxt.tprev   = din.ty;
        nxt.ty      = din.ty + ONE;
        nxt.my      = din.neg_y ? din.my - 6'sd1 : din.my + 6'sd1;
        nxt.side    = 1'b1;
        nxt.stepped = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= nxt;
    end
  end

endmodule

// ===== src/grcc_div_step.sv =====
// One restoring-division stage: resolves a single quotient bit of the slice height.
module grcc_div_step (
  input  logic           clk,
  input  logic           rst,
  input  logic           en,
  input  logic [3:0]     bit_pos,
  input  grcc_pkg::div_t din,
  output grcc_pkg::div_t dout
);
  import grcc_pkg::*;

  logic [29:0] trial;
  div_t        nxt;

  assign trial = 30'(din.den) << bit_pos;

  always_comb begin
    nxt = din;
    if (30'(din.rem) >= trial) begin
      nxt.rem = din.rem - trial[26:0];
      nxt.quot[bit_pos] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (en) begin
      dout <= nxt;
    end
  end

endmodule

// ===== src/grid_ray_cast_column_top.sv =====
// Grid ray caster top level: camera setup, unrolled DDA walk, slice height divide.
// Pipeline stages from input request to result: 3 setup stages, 18 DDA step
// stages, 2 stages for the height numerator and overflow test, 13 divider stages,
// 1 output stage. Throughput: one column per cycle; the whole pipeline holds
// while the output request waits. Reset clears all stage valid bits and loads the
// register defaults.
module grid_ray_cast_column_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [63:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [9:0] column
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // [9:0] out_column, [20:10] draw_start, [31:21] draw_end,
                                 // [32] side, [35:33] hit_x, [38:36] hit_y
);
  import grcc_pkg::*;

  logic [14:0]        player_x;
  logic [14:0]        player_y;
  logic signed [14:0] dir_x;
  logic signed [14:0] dir_y;
  logic signed [14:0] plane_x;
  logic signed [14:0] plane_y;
  logic [63:0]        map_walls;
  logic [9:0]         screen_height;

  always_ff @(posedge clk) begin
    if (rst) begin
      player_x      <= 15'd6144;
      player_y      <= 15'd6144;
      dir_x         <= 15'sd4096;
      dir_y         <= 15'sd0;
      plane_x       <= 15'sd0;
      plane_y       <= 15'sd2703;
      map_walls     <= '1;
      screen_height <= 10'd480;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_addr))
        REG_PLAYER_X:      player_x      <= cfg_data[14:0];
        REG_PLAYER_Y:      player_y      <= cfg_data[14:0];
        REG_DIR_X:         dir_x         <= cfg_data[14:0];
        REG_DIR_Y:         dir_y         <= cfg_data[14:0];
        REG_PLANE_X:       plane_x       <= cfg_data[14:0];
        REG_PLANE_Y:       plane_y       <= cfg_data[14:0];
        REG_MAP_WALLS:     map_walls     <= cfg_data;
        REG_SCREEN_HEIGHT: screen_height <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // stage 1: camera offset
  logic              s1_valid;
  logic [9:0]        s1_column;
  logic signed [14:0] s1_cam;
  logic [15:0]       cam_num;
  logic [32:0]       cam_prod;
  logic [14:0]       cam_quot;

  assign cam_num  = 16'(s_tdata[9:0]) << CAM_MUL_SHIFT;
  assign cam_prod = 33'(cam_num) * 33'(CAM_RECIP);
  assign cam_quot = cam_prod[CAM_RECIP_SHIFT +: 15];

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_column <= s_tdata[9:0];
      s1_cam    <= $signed(cam_quot - 15'(ONE));
    end
  end

  // stage 2: plane scaling
  logic               s2_valid;
  logic [9:0]         s2_column;
  logic signed [29:0] s2_px;
  logic signed [29:0] s2_py;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_column <= s1_column;
      s2_px     <= 30'(s1_cam) * 30'(plane_x);
      s2_py     <= 30'(s1_cam) * 30'(plane_y);
    end
  end

  // stage 3: ray direction and DDA start state
  logic signed [17:0] ray_x;
  logic signed [17:0] ray_y;
  dda_t               dda_start;
  dda_t               dda_pipe [0:DDA_STEPS];

  assign ray_x = 18'(dir_x) + 18'(s2_px >>> FRAC_BITS);
  assign ray_y = 18'(dir_y) + 18'(s2_py >>> FRAC_BITS);

  always_comb begin
    dda_start         = '0;
    dda_start.valid   = s2_valid;
    dda_start.column  = s2_column;
    dda_start.neg_x   = ray_x[17];
    dda_start.neg_y   = ray_y[17];
    dda_start.ax      = ray_x[17] ? 17'(-ray_x) : ray_x[16:0];
    dda_start.ay      = ray_y[17] ? 17'(-ray_y) : ray_y[16:0];
    dda_start.tx      = ray_x[17] ? 17'(player_x[FRAC_BITS-1:0])
                                  : ONE - 17'(player_x[FRAC_BITS-1:0]);
    dda_start.ty      = ray_y[17] ? 17'(player_y[FRAC_BITS-1:0])
                                  : ONE - 17'(player_y[FRAC_BITS-1:0]);
    dda_start.mx      = 6'(player_x[14:FRAC_BITS]);
    dda_start.my      = 6'(player_y[14:FRAC_BITS]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dda_pipe[0].valid <= 1'b0;
    end else if (adv) begin
      dda_pipe[0] <= dda_start;
    end
  end

  for (genvar i = 0; i < DDA_STEPS; i++) begin : g_dda
    grcc_dda_step u_step (
      .clk       (clk),
      .rst       (rst),
      .en        (adv),
      .map_walls (map_walls),
      .din       (dda_pipe[i]),
      .dout      (dda_pipe[i+1])
    );
  end

  // numerator of the slice height
  dda_t        dda_end;
  logic        nm_valid;
  logic [9:0]  nm_column;
  logic        nm_side;
  logic [2:0]  nm_hit_x;
  logic [2:0]  nm_hit_y;
  logic [26:0] nm_num;
  logic [16:0] nm_den;
  logic        nm_force;

  assign dda_end = dda_pipe[DDA_STEPS];

  always_ff @(posedge clk) begin
    if (rst) begin
      nm_valid <= 1'b0;
    end else if (adv) begin
      nm_valid <= dda_end.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nm_column <= dda_end.column;
      nm_side   <= dda_end.side;
      nm_hit_x  <= clamp_cell(dda_end.mx);
      nm_hit_y  <= clamp_cell(dda_end.my);
      nm_num    <= 27'(screen_height) * 27'(dda_end.side ? dda_end.ay : dda_end.ax);
      nm_den    <= dda_end.tprev;
      nm_force  <= !dda_end.stepped || dda_end.tprev == 17'd0;
    end
  end

  // overflow test ahead of the divider
  div_t div_start;
  div_t div_pipe [0:DIV_BITS];

  always_comb begin
    div_start        = '0;
    div_start.valid  = nm_valid;
    div_start.column = nm_column;
    div_start.side   = nm_side;
    div_start.hit_x  = nm_hit_x;
    div_start.hit_y  = nm_hit_y;
    div_start.half_h = screen_height[9:1];
    div_start.rem    = nm_num;
    div_start.den    = nm_den;
    div_start.sat    = nm_force || (30'(nm_num) >= (30'(nm_den) << DIV_BITS));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_pipe[0].valid <= 1'b0;
    end else if (adv) begin
      div_pipe[0] <= div_start;
    end
  end

  for (genvar b = 0; b < DIV_BITS; b++) begin : g_div
    grcc_div_step u_step (
      .clk     (clk),
      .rst     (rst),
      .en      (adv),
      .bit_pos (4'(DIV_BITS - 1 - b)),
      .din     (div_pipe[b]),
      .dout    (div_pipe[b+1])
    );
  end

  // output stage
  div_t               div_end;
  logic [11:0]        line_h;
  logic [10:0]        half_l;
  logic signed [10:0] draw_start;
  logic [10:0]        draw_end;
  logic [9:0]         out_column;
  logic               out_side;
  logic [2:0]         out_hit_x;
  logic [2:0]         out_hit_y;

  assign div_end = div_pipe[DIV_BITS];

  always_comb begin
    if (div_end.sat || div_end.quot > 13'(LINE_SAT)) begin
      line_h = 12'(LINE_SAT);
    end else begin
      line_h = div_end.quot[11:0];
    end
  end

  assign half_l = line_h[11:1];

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= div_end.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      draw_start <= $signed(11'(div_end.half_h) - half_l);
      draw_end   <= 11'(div_end.half_h) + half_l;
      out_column <= div_end.column;
      out_side   <= div_end.side;
      out_hit_x  <= div_end.hit_x;
      out_hit_y  <= div_end.hit_y;
    end
  end

  assign m_tdata = {1'b0, out_hit_y, out_hit_x, out_side, draw_end, draw_start, out_column};

endmodule
